// ----- hdl/npp_pkg.sv -----
`timescale 1ns / 1ps

package npp_pkg;

    localparam int MAX_LINE_CHARS = 255;
    localparam int FIELD_SLOTS    = 16;
    localparam int LAST_FIELD     = FIELD_SLOTS - 1;
    localparam int INT_CAP        = 999999;
    localparam int LAT_LIMIT      = 900000000;
    localparam int LON_LIMIT      = 1800000000;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_1      = 8'h31;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_V      = 8'h56;
    localparam logic [7:0] CH_W      = 8'h57;
    localparam logic [7:0] CH_S_LOW  = 8'h73;
    localparam logic [7:0] CH_W_LOW  = 8'h77;

    localparam logic REP_FIX = 1'b0;
    localparam logic REP_SAT = 1'b1;

    typedef enum logic [1:0] {
        K_UNKNOWN,
        K_GGA,
        K_RMC,
        K_GSV
    } t_kind;

    typedef enum logic [3:0] {
        R_NONE,
        R_TIME,
        R_LAT,
        R_LATH,
        R_LON,
        R_LONH,
        R_QUAL,
        R_COUNT,
        R_HDOP
    } t_role;

    typedef struct packed {
        logic [19:0] ival;
        logic [16:0] frac;
        logic [6:0]  two;
        logic [2:0]  fd;
        logic        point;
        logic        stop;
        logic        digit;
        logic        first;
    } t_scan;

    typedef struct packed {
        logic [19:0] lat_int;
        logic [16:0] lat_frac;
        logic [19:0] lon_int;
        logic [16:0] lon_frac;
        logic        lat_neg;
        logic        lon_neg;
        logic        lat_ok;
        logic        lon_ok;
        logic        qual;
        logic [7:0]  count;
        logic [13:0] hdop;
        logic [19:0] time_int;
        logic [6:0]  time_two;
    } t_acc;

    typedef struct packed {
        t_acc        acc;
        t_scan       scan;
        t_kind       kind;
        logic [4:0]  field;
        logic        bad;
    } t_line;

    localparam t_scan SCAN_CLEAR = '{ival: '0, frac: '0, two: '0, fd: '0, point: 1'b0,
                                     stop: 1'b0, digit: 1'b0, first: 1'b1};

    function automatic t_role f_role(input t_kind kind, input logic [4:0] field);
        t_role role;
        role = R_NONE;
        case (kind)
            K_GGA: begin
                case (field)
                    5'd1: role = R_TIME;
                    5'd2: role = R_LAT;
                    5'd3: role = R_LATH;
                    5'd4: role = R_LON;
                    5'd5: role = R_LONH;
                    5'd6: role = R_QUAL;
                    5'd7: role = R_COUNT;
                    5'd8: role = R_HDOP;
                    default: role = R_NONE;
                endcase
            end
            K_RMC: begin
                case (field)
                    5'd1: role = R_TIME;
                    5'd2: role = R_QUAL;
                    5'd3: role = R_LAT;
                    5'd4: role = R_LATH;
                    5'd5: role = R_LON;
                    5'd6: role = R_LONH;
                    default: role = R_NONE;
                endcase
            end
            K_GSV: begin
                if (field == 5'd2) begin
                    role = R_QUAL;
                end else if (field == 5'd3) begin
                    role = R_COUNT;
                end
            end
            default: role = R_NONE;
        endcase
        return role;
    endfunction

    function automatic t_acc f_field_end(input t_role role, input t_scan s, input t_acc a);
        t_acc        r;
        logic [26:0] h;
        r = a;
        h = 27'(s.ival) * 27'd100 + 27'(s.two);
        case (role)
            R_TIME: begin
                r.time_int = s.ival;
                r.time_two = s.two;
            end
            R_LAT: begin
                r.lat_int  = s.ival;
                r.lat_frac = s.frac;
                if (s.digit) r.lat_ok = 1'b1;
            end
            R_LON: begin
                r.lon_int  = s.ival;
                r.lon_frac = s.frac;
                if (s.digit) r.lon_ok = 1'b1;
            end
            R_COUNT: r.count = (s.ival > 20'd255) ? 8'd255 : s.ival[7:0];
            R_HDOP:  r.hdop  = (h > 27'd9999) ? 14'd9999 : h[13:0];
            default: r = a;
        endcase
        return r;
    endfunction

endpackage

// ----- hdl/npp_front.sv -----
`timescale 1ns / 1ps

module npp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_char_code,
    input  logic          i_line_end,
    input  logic          i_full,
    output logic          o_push,
    output npp_pkg::t_line o_line
);
    import npp_pkg::*;

    logic [7:0] r_count, n_count;
    logic [4:0] r_field, n_field;
    t_kind      r_kind, n_kind;
    logic       r_nod, n_nod;
    logic       r_star, n_star;
    t_acc       r_acc, n_acc;
    t_scan      r_scan, n_scan;

    always_comb begin
        t_role       role;
        logic [7:0]  c;
        logic [7:0]  want;
        logic [3:0]  d;
        logic [23:0] ni;
        logic [16:0] w;
        role    = f_role(r_kind, r_field);
        c       = i_char_code;
        d       = c[3:0];
        ni      = 24'(r_scan.ival) * 24'd10 + 24'(d);
        case (r_scan.fd)
            3'd0:    w = 17'd10000;
            3'd1:    w = 17'd1000;
            3'd2:    w = 17'd100;
            3'd3:    w = 17'd10;
            default: w = 17'd1;
        endcase
        want    = (r_kind == K_GGA) ? CH_0 : ((r_kind == K_RMC) ? CH_A : CH_1);
        n_count = r_count;
        n_field = r_field;
        n_kind  = r_kind;
        n_nod   = r_nod;
        n_star  = r_star;
        n_acc   = r_acc;
        n_scan  = r_scan;
        o_push  = 1'b0;
        if (i_valid && !i_full) begin
            if (r_count < 8'(MAX_LINE_CHARS)) begin
                n_count = r_count + 8'd1;
                if (r_count == 8'd0 && c != CH_DOLLAR) n_nod = 1'b1;
                if (!n_nod && !r_star) begin
                    if (c == CH_STAR) begin
                        n_star = 1'b1;
                        if (r_count < 8'd6) n_kind = K_UNKNOWN;
                    end else if (r_field == 5'd0) begin
                        case (r_count)
                            8'd3: begin
                                n_kind = (c == CH_G) ? K_GGA : ((c == CH_R) ? K_RMC : K_UNKNOWN);
                            end
                            8'd4: begin
                                if (r_kind == K_GGA) begin
                                    n_kind = (c == CH_G) ? K_GGA : ((c == CH_S) ? K_GSV : K_UNKNOWN);
                                end else if (r_kind == K_RMC) begin
                                    n_kind = (c == CH_M) ? K_RMC : K_UNKNOWN;
                                end
                            end
                            8'd5: begin
                                if (c != ((r_kind == K_GGA) ? CH_A :
                                          ((r_kind == K_RMC) ? CH_C : CH_V))) begin
                                    n_kind = K_UNKNOWN;
                                end
                            end
                            default: n_kind = r_kind;
                        endcase
                        if (c == CH_COMMA) begin
                            n_field = 5'd1;
                            n_scan  = SCAN_CLEAR;
                        end
                    end else if (c == CH_COMMA && r_field < 5'(LAST_FIELD)) begin
                        n_acc   = f_field_end(role, r_scan, r_acc);
                        n_field = r_field + 5'd1;
                        n_scan  = SCAN_CLEAR;
                    end else begin
                        if (r_scan.first) begin
                            n_scan.first = 1'b0;
                            if (role == R_LATH || role == R_LONH) begin
                                if (c inside {CH_S, CH_S_LOW, CH_W, CH_W_LOW}) begin
                                    if (role == R_LATH) n_acc.lat_neg = 1'b1;
                                    else n_acc.lon_neg = 1'b1;
                                end
                            end else if (role == R_QUAL) begin
                                n_acc.qual = (c == want);
                            end
                        end
                        if (!r_scan.stop) begin
                            if (c inside {[CH_0:CH_9]}) begin
                                if (!r_scan.point) begin
                                    n_scan.ival = (ni > 24'(INT_CAP)) ? 20'(INT_CAP) : ni[19:0];
                                end else if (r_scan.fd < 3'd5) begin
                                    n_scan.frac = r_scan.frac + 17'(w * 17'(d));
                                    if (r_scan.fd == 3'd0) begin
                                        n_scan.two = 7'(d) * 7'd10;
                                    end else if (r_scan.fd == 3'd1) begin
                                        n_scan.two = r_scan.two + 7'(d);
                                    end
                                    n_scan.fd = r_scan.fd + 3'd1;
                                end
                                n_scan.digit = 1'b1;
                            end else if (c == CH_POINT && !r_scan.point) begin
                                n_scan.point = 1'b1;
                            end else begin
                                n_scan.stop = 1'b1;
                            end
                        end
                    end
                end
            end
            if (i_line_end) begin
                o_push = 1'b1;
            end
        end
        o_line.acc   = n_acc;
        o_line.scan  = n_scan;
        o_line.kind  = n_kind;
        o_line.field = n_field;
        o_line.bad   = n_nod || (n_count < 8'd6);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_count <= '0;
            r_field <= '0;
            r_kind  <= K_UNKNOWN;
            r_nod   <= 1'b0;
            r_star  <= 1'b0;
            r_acc   <= '0;
            r_scan  <= SCAN_CLEAR;
        end else begin
            r_count <= n_count;
            r_field <= n_field;
            r_kind  <= n_kind;
            r_nod   <= n_nod;
            r_star  <= n_star;
            r_acc   <= n_acc;
            r_scan  <= n_scan;
        end
    end

endmodule

// ----- hdl/npp_queue.sv -----
`timescale 1ns / 1ps

module npp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  npp_pkg::t_line i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output npp_pkg::t_line o_data
);
    import npp_pkg::*;

    t_line      r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_fill;

    assign o_full  = (r_fill == 2'd2);
    assign o_empty = (r_fill == 2'd0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_fill <= '0;
        end else begin
            if (i_push) r_wptr <= ~r_wptr;
            if (i_pop)  r_rptr <= ~r_rptr;
            r_fill <= r_fill + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

// ----- hdl/npp_back.sv -----
`timescale 1ns / 1ps

module npp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  npp_pkg::t_line i_line,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_stall,
    output logic           o_report_kind,
    output logic [30:0]    o_latitude,
    output logic [31:0]    o_longitude,
    output logic [7:0]     o_satellites,
    output logic [13:0]    o_hdop,
    output logic [19:0]    o_utc_hhmmss,
    output logic [6:0]     o_utc_hundredths,
    output logic           o_last_of_run
);
    import npp_pkg::*;

    localparam int NSTG = 7;

    typedef struct packed {
        logic [19:0] ip;
        logic [16:0] fr;
        logic        neg;
        logic [13:0] q;
        logic [7:0]  r;
        logic [25:0] y;
        logic [24:0] q3;
        logic [31:0] mag;
    } t_coord;

    typedef struct packed {
        t_acc       acc;
        t_kind      kind;
        logic [4:0] field;
        logic       bad;
        t_coord     lat;
        t_coord     lon;
    } t_bk;

    typedef struct packed {
        logic        kind;
        logic [30:0] lat;
        logic [31:0] lon;
        logic [7:0]  sats;
        logic [13:0] hdop;
        logic [19:0] utc;
        logic [6:0]  hund;
        logic        last;
    } t_item;

    function automatic t_coord f_step(input int k, input t_coord c, input logic [33:0] limit);
        t_coord      o;
        logic [35:0] p1;
        logic [20:0] rr;
        logic [50:0] p3;
        logic [26:0] rem;
        logic [7:0]  degc;
        logic [33:0] m;
        o    = c;
        p1   = 36'(c.ip) * 36'd41943;
        rr   = 21'(c.ip) - 21'(c.q) * 21'd100;
        p3   = 51'(c.y) * 51'd22369621;
        rem  = 27'(c.y) - 27'(c.q3) * 27'd3;
        degc = (c.q > 14'd255) ? 8'd255 : c.q[7:0];
        m    = 34'(degc) * 34'd10000000 + 34'(c.q3);
        case (k)
            1: o.q = p1[35:22];
            2: begin
                if (rr >= 21'd100) begin
                    o.q = c.q + 14'd1;
                    o.r = 8'(rr - 21'd100);
                end else begin
                    o.r = rr[7:0];
                end
            end
            3: o.y = 26'(c.r) * 26'd500000 + 26'(c.fr) * 26'd5;
            4: o.q3 = p3[50:26];
            5: if (rem >= 27'd3) o.q3 = c.q3 + 25'd1;
            default: begin
                if (m > limit) m = limit;
                o.mag = c.neg ? (32'd0 - m[31:0]) : m[31:0];
            end
        endcase
        return o;
    endfunction

    t_bk         r_st [NSTG];
    logic [NSTG-1:0] r_v;
    logic        r_em_v, r_em_two, r_em_idx;
    t_item       r_it0, r_it1;
    logic [7:0]  r_sto_sats;
    logic [13:0] r_sto_hdop;

    logic        en, out_acc, out_done;
    t_bk         head;
    t_item       it0, it1, cur;
    logic [1:0]  nres;
    logic        sto_upd;

    assign cur      = r_em_idx ? r_it1 : r_it0;
    assign o_valid  = r_em_v;
    assign out_acc  = r_em_v && !i_stall;
    assign out_done = out_acc && (r_em_idx || !r_em_two);
    assign en       = !r_em_v || out_done;
    assign o_pop    = en && !i_empty;

    assign o_report_kind    = cur.kind;
    assign o_latitude       = cur.lat;
    assign o_longitude      = cur.lon;
    assign o_satellites     = cur.sats;
    assign o_hdop           = cur.hdop;
    assign o_utc_hhmmss     = cur.utc;
    assign o_utc_hundredths = cur.hund;
    assign o_last_of_run    = cur.last;

    always_comb begin
        head.acc   = i_line.acc;
        if (i_line.field != 5'd0) begin
            head.acc = f_field_end(f_role(i_line.kind, i_line.field), i_line.scan, i_line.acc);
        end
        head.kind  = i_line.kind;
        head.field = i_line.field;
        head.bad   = i_line.bad;
        head.lat   = '0;
        head.lon   = '0;
        head.lat.ip  = head.acc.lat_int;
        head.lat.fr  = head.acc.lat_frac;
        head.lat.neg = head.acc.lat_neg;
        head.lon.ip  = head.acc.lon_int;
        head.lon.fr  = head.acc.lon_frac;
        head.lon.neg = head.acc.lon_neg;
    end

    always_comb begin
        t_bk  b;
        logic both;
        b    = r_st[NSTG-1];
        both = b.acc.lat_ok && b.acc.lon_ok;
        nres    = 2'd0;
        sto_upd = 1'b0;
        it0 = '{kind: REP_SAT, lat: '0, lon: '0, sats: b.acc.count, hdop: '0, utc: '0,
                hund: '0, last: 1'b1};
        it1 = it0;
        if (!b.bad) begin
            if (b.kind == K_GGA && b.field >= 5'd8) begin
                if (b.acc.qual) begin
                    nres = 2'd1;
                end else if (both) begin
                    nres    = 2'd2;
                    sto_upd = 1'b1;
                    it0 = '{kind: REP_FIX, lat: b.lat.mag[30:0], lon: b.lon.mag,
                            sats: b.acc.count, hdop: b.acc.hdop, utc: b.acc.time_int,
                            hund: b.acc.time_two, last: 1'b0};
                end
            end else if (b.kind == K_RMC && b.field >= 5'd6 && b.acc.qual && both) begin
                nres = 2'd1;
                it0 = '{kind: REP_FIX, lat: b.lat.mag[30:0], lon: b.lon.mag,
                        sats: r_sto_sats, hdop: r_sto_hdop, utc: b.acc.time_int,
                        hund: b.acc.time_two, last: 1'b1};
            end else if (b.kind == K_GSV && b.field >= 5'd3 && b.acc.qual) begin
                nres = 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_st[0] <= head;
            for (int k = 1; k < NSTG; k++) begin
                r_st[k].acc   <= r_st[k-1].acc;
                r_st[k].kind  <= r_st[k-1].kind;
                r_st[k].field <= r_st[k-1].field;
                r_st[k].bad   <= r_st[k-1].bad;
                r_st[k].lat   <= f_step(k, r_st[k-1].lat, 34'(LAT_LIMIT));
                r_st[k].lon   <= f_step(k, r_st[k-1].lon, 34'(LON_LIMIT));
            end
        end
        if (en && r_v[NSTG-1] && nres != 2'd0) begin
            r_it0 <= it0;
            r_it1 <= it1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v        <= '0;
            r_em_v     <= 1'b0;
            r_em_two   <= 1'b0;
            r_em_idx   <= 1'b0;
            r_sto_sats <= '0;
            r_sto_hdop <= '0;
        end else begin
            if (en) begin
                r_v <= {r_v[NSTG-2:0], !i_empty};
                if (r_v[NSTG-1] && nres != 2'd0) begin
                    r_em_v   <= 1'b1;
                    r_em_two <= (nres == 2'd2);
                    r_em_idx <= 1'b0;
                    if (sto_upd) begin
                        r_sto_sats <= r_st[NSTG-1].acc.count;
                        r_sto_hdop <= r_st[NSTG-1].acc.hdop;
                    end
                end else begin
                    r_em_v <= 1'b0;
                end
            end else if (out_acc) begin
                r_em_idx <= 1'b1;
            end
        end
    end

endmodule

// ----- hdl/nmea_position_sentence_parser.sv -----
`timescale 1ns / 1ps

// NMEA position sentence parser for GGA, RMC and GSV lines.
// The input channel takes one character per item, with i_line_end set on the
// last character of a line. A character is taken in every cycle that the small
// line queue has room, so the sustained rate is one item per clock.
// The front end decodes fields as characters stream past. At the line end it
// hands a summary of the line to a two-entry queue; a seven-stage back end
// converts the coordinates to 1e-7 degrees and decides which reports to send.
// Each line gives zero, one or two result items. Its summary passes the queue,
// the seven back-end stages and the output register, and a second result
// follows once the first is taken. o_last_of_run marks a line's final result.
// When the receiver holds i_stall, the current result stays on the outputs and
// the back end freezes; the front end keeps taking characters until the queue
// holds two finished lines, and then o_stall is raised.
// A synchronous reset clears the line state, the queue, the back end and the
// stored satellite count and hdop that RMC fixes reuse.
module nmea_position_sentence_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char_code,
    input  logic        i_line_end,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_report_kind,
    output logic [30:0] o_latitude,
    output logic [31:0] o_longitude,
    output logic [7:0]  o_satellites,
    output logic [13:0] o_hdop,
    output logic [19:0] o_utc_hhmmss,
    output logic [6:0]  o_utc_hundredths,
    output logic        o_last_of_run
);
    import npp_pkg::*;

    logic  push, full, pop, empty;
    t_line line_in, line_out;

    assign o_stall = full;

    npp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_char_code (i_char_code),
        .i_line_end  (i_line_end),
        .i_full      (full),
        .o_push      (push),
        .o_line      (line_in)
    );

    npp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (line_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (line_out)
    );

    npp_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_empty          (empty),
        .i_line           (line_out),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_report_kind    (o_report_kind),
        .o_latitude       (o_latitude),
        .o_longitude      (o_longitude),
        .o_satellites     (o_satellites),
        .o_hdop           (o_hdop),
        .o_utc_hhmmss     (o_utc_hhmmss),
        .o_utc_hundredths (o_utc_hundredths),
        .o_last_of_run    (o_last_of_run)
    );

endmodule

// ----- tb/tb_nmea_position_sentence_parser.sv -----
`timescale 1ns / 1ps

module tb_nmea_position_sentence_parser;
    import npp_pkg::*;

    typedef struct packed {
        logic        kind;
        logic [30:0] lat;
        logic [31:0] lon;
        logic [7:0]  sats;
        logic [13:0] hdop;
        logic [19:0] hhmmss;
        logic [6:0]  hund;
        logic        last;
    } t_report;

    class report_scoreboard;
        t_report     reports_due[$];
        int unsigned mismatches;
        int unsigned reports_seen;

        int unsigned     n_chars;
        int unsigned     field_no;
        t_kind           kind;
        bit              no_dollar;
        bit              star_seen;
        longint unsigned lat_val;
        longint unsigned lon_val;
        bit              lat_neg, lon_neg, lat_ok, lon_ok;
        bit              qual_hit;
        int unsigned     count_val;
        int unsigned     hdop_val;
        int unsigned     time_val;
        int unsigned     kept_sats;
        int unsigned     kept_hdop;

        longint unsigned num_int;
        longint unsigned num_frac;
        int unsigned     num_fd;
        bit              num_point, num_stop, num_digit, num_first;

        function new();
            kept_sats = 0;
            kept_hdop = 0;
            clear_line();
        endfunction

        function void clear_number();
            num_int = 0;
            num_frac = 0;
            num_fd = 0;
            num_point = 0;
            num_stop = 0;
            num_digit = 0;
            num_first = 1;
        endfunction

        function void clear_line();
            n_chars = 0;
            field_no = 0;
            kind = K_UNKNOWN;
            no_dollar = 0;
            star_seen = 0;
            lat_val = 0;
            lon_val = 0;
            lat_neg = 0;
            lon_neg = 0;
            lat_ok = 0;
            lon_ok = 0;
            qual_hit = 0;
            count_val = 0;
            hdop_val = 0;
            time_val = 0;
            clear_number();
        endfunction

        function t_role field_role();
            t_role r;
            r = R_NONE;
            if (kind == K_GGA) begin
                case (field_no)
                    1: r = R_TIME;
                    2: r = R_LAT;
                    3: r = R_LATH;
                    4: r = R_LON;
                    5: r = R_LONH;
                    6: r = R_QUAL;
                    7: r = R_COUNT;
                    8: r = R_HDOP;
                    default: r = R_NONE;
                endcase
            end else if (kind == K_RMC) begin
                case (field_no)
                    1: r = R_TIME;
                    2: r = R_QUAL;
                    3: r = R_LAT;
                    4: r = R_LATH;
                    5: r = R_LON;
                    6: r = R_LONH;
                    default: r = R_NONE;
                endcase
            end else if (kind == K_GSV) begin
                if (field_no == 2) r = R_QUAL;
                if (field_no == 3) r = R_COUNT;
            end
            return r;
        endfunction

        function void take_field_char(byte unsigned c);
            t_role       r;
            byte unsigned want;
            r = field_role();
            if (num_first) begin
                num_first = 0;
                if (r == R_LATH || r == R_LONH) begin
                    if (c == CH_S || c == CH_S_LOW || c == CH_W || c == CH_W_LOW) begin
                        if (r == R_LATH) lat_neg = 1;
                        else lon_neg = 1;
                    end
                end else if (r == R_QUAL) begin
                    want = (kind == K_GGA) ? CH_0 : ((kind == K_RMC) ? CH_A : CH_1);
                    qual_hit = (c == want);
                end
            end
            if (num_stop) return;
            if (c >= CH_0 && c <= CH_9) begin
                if (!num_point) begin
                    num_int = num_int * 10 + (c - CH_0);
                    if (num_int > INT_CAP) num_int = INT_CAP;
                end else if (num_fd < 5) begin
                    num_frac = num_frac * 10 + (c - CH_0);
                    num_fd++;
                end
                num_digit = 1;
            end else if (c == CH_POINT && !num_point) begin
                num_point = 1;
            end else begin
                num_stop = 1;
            end
        endfunction

        function void close_field();
            t_role           r;
            longint unsigned padded, two, h;
            r = field_role();
            padded = num_frac * (10 ** (5 - num_fd));
            two = padded / 1000;
            case (r)
                R_TIME: time_val = 32'(num_int * 100 + two);
                R_LAT: begin
                    lat_val = num_int * 100000 + padded;
                    if (num_digit) lat_ok = 1;
                end
                R_LON: begin
                    lon_val = num_int * 100000 + padded;
                    if (num_digit) lon_ok = 1;
                end
                R_COUNT: count_val = (num_int > 255) ? 255 : 32'(num_int);
                R_HDOP: begin
                    h = num_int * 100 + two;
                    hdop_val = (h > 9999) ? 9999 : 32'(h);
                end
                default: ;
            endcase
        endfunction

        function longint unsigned degrees_e7(longint unsigned v, bit neg,
                                             longint unsigned limit);
            longint unsigned ip, mins, mag;
            ip = v / 100000;
            mins = (ip % 100) * 100000 + v % 100000;
            mag = (ip / 100) * 10000000 + mins * 100 / 60;
            if (mag > limit) mag = limit;
            return neg ? (0 - mag) : mag;
        endfunction

        function void queue_report(bit k, longint unsigned la, longint unsigned lo,
                                   int unsigned s, int unsigned hd, int unsigned t, bit l);
            t_report r;
            r.kind = k;
            r.lat = la[30:0];
            r.lon = lo[31:0];
            r.sats = s[7:0];
            r.hdop = hd[13:0];
            r.hhmmss = 20'(t / 100);
            r.hund = 7'(t % 100);
            r.last = l;
            reports_due.push_back(r);
        endfunction

        function void close_line();
            longint unsigned la, lo;
            bit              both;
            both = lat_ok && lon_ok;
            if (no_dollar || n_chars < 6) return;
            la = degrees_e7(lat_val, lat_neg, LAT_LIMIT);
            lo = degrees_e7(lon_val, lon_neg, LON_LIMIT);
            if (kind == K_GGA && field_no >= 8) begin
                if (qual_hit) begin
                    queue_report(REP_SAT, 0, 0, count_val, 0, 0, 1);
                end else if (both) begin
                    kept_sats = count_val;
                    kept_hdop = hdop_val;
                    queue_report(REP_FIX, la, lo, kept_sats, kept_hdop, time_val, 0);
                    queue_report(REP_SAT, 0, 0, kept_sats, 0, 0, 1);
                end
            end else if (kind == K_RMC && field_no >= 6 && qual_hit && both) begin
                queue_report(REP_FIX, la, lo, kept_sats, kept_hdop, time_val, 1);
            end else if (kind == K_GSV && field_no >= 3 && qual_hit) begin
                queue_report(REP_SAT, 0, 0, count_val, 0, 0, 1);
            end
        endfunction

        function void note_char(byte unsigned c, bit line_end);
            int unsigned pos;
            if (n_chars < MAX_LINE_CHARS) begin
                pos = n_chars;
                n_chars++;
                if (pos == 0 && c != CH_DOLLAR) no_dollar = 1;
                if (!no_dollar && !star_seen) begin
                    if (c == CH_STAR) begin
                        star_seen = 1;
                        if (pos < 6) kind = K_UNKNOWN;
                    end else if (field_no == 0) begin
                        if (pos == 3) begin
                            kind = (c == CH_G) ? K_GGA : ((c == CH_R) ? K_RMC : K_UNKNOWN);
                        end else if (pos == 4) begin
                            if (kind == K_GGA)
                                kind = (c == CH_G) ? K_GGA : ((c == CH_S) ? K_GSV : K_UNKNOWN);
                            else if (kind == K_RMC)
                                kind = (c == CH_M) ? K_RMC : K_UNKNOWN;
                        end else if (pos == 5) begin
                            if (c != ((kind == K_GGA) ? CH_A : ((kind == K_RMC) ? CH_C : CH_V)))
                                kind = K_UNKNOWN;
                        end
                        if (c == CH_COMMA) begin
                            field_no = 1;
                            clear_number();
                        end
                    end else if (c == CH_COMMA && field_no < LAST_FIELD) begin
                        close_field();
                        field_no++;
                        clear_number();
                    end else begin
                        take_field_char(c);
                    end
                end
            end
            if (line_end) begin
                if (field_no > 0) close_field();
                close_line();
                clear_line();
            end
        endfunction

        function void check_report(t_report got);
            t_report want;
            reports_seen++;
            if (reports_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result item: %p", got);
                return;
            end
            want = reports_due.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Result mismatch at %0t", $realtime);
                    $display("  expected kind=%0d lat=%0d lon=%0d sats=%0d hdop=%0d utc=%0d.%0d last=%0d",
                             want.kind, $signed(want.lat), $signed(want.lon), want.sats,
                             want.hdop, want.hhmmss, want.hund, want.last);
                    $display("  actual   kind=%0d lat=%0d lon=%0d sats=%0d hdop=%0d utc=%0d.%0d last=%0d",
                             got.kind, $signed(got.lat), $signed(got.lon), got.sats,
                             got.hdop, got.hhmmss, got.hund, got.last);
                end
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_char_code = 8'd0;
    logic        i_line_end = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_report_kind;
    logic [30:0] o_latitude;
    logic [31:0] o_longitude;
    logic [7:0]  o_satellites;
    logic [13:0] o_hdop;
    logic [19:0] o_utc_hhmmss;
    logic [6:0]  o_utc_hundredths;
    logic        o_last_of_run;

    report_scoreboard sb = new();
    bit               calm = 1'b0;
    int               stall_left = 0;
    int               chars_sent = 0;

    nmea_position_sentence_parser u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_char_code      (i_char_code),
        .i_line_end       (i_line_end),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_report_kind    (o_report_kind),
        .o_latitude       (o_latitude),
        .o_longitude      (o_longitude),
        .o_satellites     (o_satellites),
        .o_hdop           (o_hdop),
        .o_utc_hhmmss     (o_utc_hhmmss),
        .o_utc_hundredths (o_utc_hundredths),
        .o_last_of_run    (o_last_of_run)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("Some tests failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall)
                sb.check_report({o_report_kind, o_latitude, o_longitude, o_satellites, o_hdop,
                                 o_utc_hhmmss, o_utc_hundredths, o_last_of_run});
            if (i_valid && !o_stall) sb.note_char(i_char_code, i_line_end);
        end
    end

    always @(negedge i_clk) begin
        if (calm || !i_rst_n) begin
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 13);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic send_char(byte unsigned c, bit line_end);
        if (!calm && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_char_code <= c;
        i_line_end <= line_end;
        do @(posedge i_clk); while (o_stall);
        chars_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_line(string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
    endtask

    function automatic string digits(int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++) s = {s, string'(8'(CH_0 + $urandom_range(0, 9)))};
        return s;
    endfunction

    function automatic string rand_number(int max_int, int max_frac);
        string s;
        s = digits($urandom_range(0, max_int));
        if ($urandom_range(0, 3) != 0) s = {s, ".", digits($urandom_range(0, max_frac))};
        case ($urandom_range(0, 19))
            0: s = {s, "-3"};
            1: s = {s, "e1"};
            2: s = {" ", s};
            3: s = {s, ".5"};
            default: ;
        endcase
        return s;
    endfunction

    function automatic string pick_hemi(bit lat_side);
        case ($urandom_range(0, 6))
            0: return lat_side ? "N" : "E";
            1: return "S";
            2: return "W";
            3: return "s";
            4: return "w";
            5: return "";
            default: return lat_side ? "N" : "E";
        endcase
    endfunction

    function automatic string talker();
        return $urandom_range(0, 1) ? "GP" : "GN";
    endfunction

    function automatic string rand_gga();
        string q;
        case ($urandom_range(0, 4))
            0: q = "0";
            1: q = "";
            2: q = "2";
            default: q = "1";
        endcase
        return {"$", talker(), "GGA,", rand_number(7, 4), ",", rand_number(5, 7), ",",
                pick_hemi(1), ",", rand_number(6, 7), ",", pick_hemi(0), ",", q, ",",
                rand_number(3, 1), ",", rand_number(3, 3), ",545.4,M,46.9,M,,*47"};
    endfunction

    function automatic string rand_rmc();
        string st;
        case ($urandom_range(0, 4))
            0: st = "V";
            1: st = "a";
            default: st = "A";
        endcase
        return {"$", talker(), "RMC,", rand_number(7, 3), ",", st, ",", rand_number(5, 7),
                ",", pick_hemi(1), ",", rand_number(6, 7), ",", pick_hemi(0),
                ",022.4,084.4,230394,003.1,W*6A"};
    endfunction

    function automatic string rand_gsv();
        string m;
        m = ($urandom_range(0, 2) != 0) ? "1" : string'(8'(CH_0 + $urandom_range(0, 9)));
        return {"$", talker(), "GSV,3,", m, ",", rand_number(4, 1),
                ",03,03,111,00,04,15,270,00*74"};
    endfunction

    function automatic string rand_noise();
        string s;
        s = "";
        for (int i = $urandom_range(1, 40); i > 0; i--)
            s = {s, string'(8'($urandom_range(1, 255)))};
        if ($urandom_range(0, 1)) s = {"$", s};
        return s;
    endfunction

    function automatic string rand_line();
        string s;
        int    n;
        case ($urandom_range(0, 9))
            0, 1, 2: s = rand_gga();
            3, 4, 5: s = rand_rmc();
            6, 7: s = rand_gsv();
            default: s = rand_noise();
        endcase
        n = $urandom_range(0, 9);
        if (n == 0) begin
            s = s.substr(0, $urandom_range(0, s.len() - 1));
        end else if (n == 1) begin
            s.putc($urandom_range(0, s.len() - 1), 8'($urandom_range(0, 255)));
        end else if (n == 2) begin
            s.putc($urandom_range(0, s.len() - 1), 8'($urandom_range(0, 127)));
        end
        return s;
    endfunction

    initial begin
        string long_line;
        int    lines;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_line("$GPGGA,123519.25,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47");
        send_line("$GPGGA,235959.99,9999999.99999,S,9999999.9999999,W,2,999,99999.99,1,M,,*00");
        send_line("$GPRMC,081836.5,A,3751.65,s,14507.36,w,0.0,360.0,130998,011.3,E*62");
        send_line("$GPGGA,,0000.000000,N,00000.0,E,0,,,,*00");
        send_line("$GNRMC,1,V,1,N,1,E");
        send_line("$GPGSV,3,1,11,03,03,111,00*74");
        send_line("$GPGSV,3,2,11*74");
        send_line("$GPGGA,1,,N,,E,,5,1.5");
        send_line("$GPGGA,1,2,N,3,E,,5");
        send_line("GPGGA,1,2,N,3,E,1,5,1.5,");
        send_line("$GPG");
        send_line("$GP*GA,1,2,N,3,E,1,5,1.5,");
        send_line("$GPGGA,1,2,N,3,E,1,5,1.5,,,,,,,,,,,,,,,,,,,,,,,,");
        long_line = "$GPGSV,3,1,";
        for (int i = 0; i < 280; i++) long_line = {long_line, "7"};
        send_line(long_line);
        send_line("$GPRMC,12.3,A,4807.038,N,01131.0,E");

        lines = 0;
        while (chars_sent < 1900) begin
            string s;
            s = rand_line();
            if (lines > 0 && chars_sent > 1500) calm = 1'b1;
            send_line(s);
            lines++;
        end
        i_valid <= 1'b0;

        while (sb.reports_due.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.reports_due.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/npp_pkg.sv
hdl/npp_front.sv
hdl/npp_queue.sv
hdl/npp_back.sv
hdl/nmea_position_sentence_parser.sv
tb/tb_nmea_position_sentence_parser.sv
